>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
package deq_pkg;

    // Stream widths: tdata is padded to whole bytes
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;
    localparam int REPORT_W = 32;
    localparam int COUNT_W  = 5;

    // Operation codes carried on s_tuser
    typedef enum logic [S_USER_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_STATUS     = 3'd4
    } op_t;

    // Result status carried on m_tuser
    typedef enum logic [M_USER_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Move command broadcast to every cell; at most one bit is set
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cell_cmd_t;

endpackage

>>> rtl/deq_cell.sv
// One cell of the queue row: a front-ordered entry, a back-ordered entry and an occupancy bit.
module deq_cell #(
    parameter int SW = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  deq_pkg::cell_cmd_t cmd,
    input  logic [SW-1:0]      push_val,
    input  logic [SW-1:0]      left_a,
    input  logic [SW-1:0]      left_b,
    input  logic               left_occ,
    input  logic [SW-1:0]      right_a,
    input  logic [SW-1:0]      right_b,
    input  logic               right_occ,
    output logic [SW-1:0]      a_val,
    output logic [SW-1:0]      b_val,
    output logic               occ
);
    import deq_pkg::*;

    logic [SW-1:0] a_reg, a_next;
    logic [SW-1:0] b_reg, b_next;
    logic          occ_reg, occ_next;
    logic          boundary;

    // This cell is the first free slot when its left neighbour is occupied and it is not
    assign boundary = left_occ & ~occ_reg;

    // Shift towards the back on a push at one end, towards the front on a pop;
    // the other ordering only fills the free slot or drops its last entry
    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        occ_next = occ_reg;
        if (cmd.push_front)
        begin
            a_next   = left_a;
            occ_next = left_occ;
            if (boundary)
            begin
                b_next = push_val;
            end
        end
        else if (cmd.push_back)
        begin
            b_next   = left_b;
            occ_next = left_occ;
            if (boundary)
            begin
                a_next = push_val;
            end
        end
        else if (cmd.pop_front)
        begin
            a_next   = right_a;
            occ_next = right_occ;
        end
        else if (cmd.pop_back)
        begin
            b_next   = right_b;
            occ_next = right_occ;
        end
    end

    // Occupancy is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // Entry payload needs no reset
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a_val = a_reg;
    assign b_val = b_reg;
    assign occ   = occ_reg;

endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue: one transaction per cycle, while s_tready is high, through
// a row of cells that shift together; results are registered in the output buffer.
// Throughput: one transaction per clock while s_tready is high.
// A two-entry output buffer keeps s_tready high while one result waits on m_tready.
// Reset clears the occupancy bits, the count and the output buffer; stored values
// are undefined until written.
module double_ended_queue #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: push_value[31:0]
    input  logic [deq_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode[2:0]
    input  logic [deq_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: popped_value[31:0], front_value[63:32], back_value[95:64],
    //          entry_count[100:96], is_empty[101], zero pad[103:102]
    output logic [deq_pkg::M_DATA_W-1:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [deq_pkg::M_USER_W-1:0]  m_tuser
);
    import deq_pkg::*;

    localparam int SW    = (VALUE_WIDTH < REPORT_W) ? VALUE_WIDTH : REPORT_W;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int RES_W = M_DATA_W + M_USER_W;

    // Sign-extend a stored entry to the reported width
    function automatic logic [REPORT_W-1:0] report(input logic [SW-1:0] v);
        logic signed [SW-1:0] sv;
        sv = v;
        return REPORT_W'(sv);
    endfunction

    logic                 accept, take;
    logic [SW-1:0]        push_st;
    cell_cmd_t            cmd;
    logic                 is_push_front, is_push_back, is_pop_front, is_pop_back;
    logic                 full, empty, overflow, underflow;
    status_t              status;

    logic [SW-1:0]        a_row   [CAPACITY];
    logic [SW-1:0]        b_row   [CAPACITY];
    logic [CAPACITY-1:0]  occ_row;

    logic [CW-1:0]        count_reg, count_next;
    logic [SW-1:0]        front_raw, back_raw;
    logic [REPORT_W-1:0]  popped, front_rep, back_rep;
    logic [CW+COUNT_W-1:0] count_ext;
    logic [RES_W-1:0]     result;

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [RES_W-1:0]     out_reg, out_next;
    logic [RES_W-1:0]     skid_reg, skid_next;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign take     = out_valid_reg & m_tready;
    assign push_st  = s_tdata[SW-1:0];

    // Decode the operation
    always_comb
    begin
        is_push_front = 1'b0;
        is_push_back  = 1'b0;
        is_pop_front  = 1'b0;
        is_pop_back   = 1'b0;
        case (s_tuser)
            OP_PUSH_FRONT: is_push_front = 1'b1;
            OP_PUSH_BACK:  is_push_back  = 1'b1;
            OP_POP_FRONT:  is_pop_front  = 1'b1;
            OP_POP_BACK:   is_pop_back   = 1'b1;
            default:       ;
        endcase
    end

    // Full and empty come straight from the end cells
    assign empty     = ~occ_row[0];
    assign full      = occ_row[CAPACITY-1];
    assign overflow  = (is_push_front | is_push_back) & full;
    assign underflow = (is_pop_front | is_pop_back) & empty;

    always_comb
    begin
        if (overflow)
        begin
            status = ST_OVERFLOW;
        end
        else if (underflow)
        begin
            status = ST_UNDERFLOW;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Broadcast only transactions that change the queue
    assign cmd.push_front = accept & is_push_front & ~full;
    assign cmd.push_back  = accept & is_push_back  & ~full;
    assign cmd.pop_front  = accept & is_pop_front  & ~empty;
    assign cmd.pop_back   = accept & is_pop_back   & ~empty;

    // Row of cells: the push value enters at the left, nothing enters at the right
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [SW-1:0] left_a, left_b, right_a, right_b;
        logic          left_occ, right_occ;

        if (i == 0)
        begin : g_first
            assign left_a   = push_st;
            assign left_b   = push_st;
            assign left_occ = 1'b1;
        end
        else
        begin : g_mid_left
            assign left_a   = a_row[i-1];
            assign left_b   = b_row[i-1];
            assign left_occ = occ_row[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_a   = a_row[i];
            assign right_b   = b_row[i];
            assign right_occ = 1'b0;
        end
        else
        begin : g_mid_right
            assign right_a   = a_row[i+1];
            assign right_b   = b_row[i+1];
            assign right_occ = occ_row[i+1];
        end

        deq_cell #(
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .push_val (push_st),
            .left_a   (left_a),
            .left_b   (left_b),
            .left_occ (left_occ),
            .right_a  (right_a),
            .right_b  (right_b),
            .right_occ(right_occ),
            .a_val    (a_row[i]),
            .b_val    (b_row[i]),
            .occ      (occ_row[i])
        );
    end

    // Track the entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_front | cmd.push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_front | cmd.pop_back)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Front and back after the operation, read from the first two cells only
    always_comb
    begin
        front_raw = a_row[0];
        back_raw  = b_row[0];
        popped    = '0;
        if (cmd.push_front)
        begin
            front_raw = push_st;
            back_raw  = empty ? push_st : b_row[0];
        end
        else if (cmd.push_back)
        begin
            front_raw = empty ? push_st : a_row[0];
            back_raw  = push_st;
        end
        else if (cmd.pop_front)
        begin
            front_raw = a_row[1];
            popped    = report(a_row[0]);
        end
        else if (cmd.pop_back)
        begin
            back_raw = b_row[1];
            popped   = report(b_row[0]);
        end
    end

    assign front_rep = (count_next == '0) ? '0 : report(front_raw);
    assign back_rep  = (count_next == '0) ? '0 : report(back_raw);
    assign count_ext = {{COUNT_W{1'b0}}, count_next};

    assign result = {status, 2'b00, (count_next == '0), count_ext[COUNT_W-1:0],
                     back_rep, front_rep, popped};

    // Two-entry output buffer: the skid entry fills only while the head waits
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg[M_DATA_W-1:0];
    assign m_tuser  = out_reg[RES_W-1:M_DATA_W];

    // Count and occupancy row must agree at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == ~occ_row[0])
        else $error("count and front occupancy disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(CAPACITY)) == occ_row[CAPACITY-1])
        else $error("count and back occupancy disagree");

    // A rejected push or pop leaves the queue untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (overflow || underflow)) |=> ($stable(count_reg) && $stable(occ_row)))
        else $error("failed operation changed the queue");

    // The skid entry only holds a result behind a waiting head
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

endmodule
